FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the background estimator.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, held off while reset is low
`define BMBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bmbs check failed");
// clocked check, also active during reset
`define BMBS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bmbs check failed");
`else
`define BMBS_ASSERT(lbl, clk, rst_n, prop)
`define BMBS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/bmbs_pkg.sv
// Package of the box-mean background estimator: sizes, codes and types.
// Depends on nothing.
`default_nettype none
package bmbs_pkg;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_DEPTH  = 64;
  localparam int COUNT_BITS = 22;

  localparam int W_BITS  = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS  = $clog2(MAX_HEIGHT + 1);
  localparam int D_BITS  = $clog2(MAX_DEPTH + 1);
  localparam int X_BITS  = $clog2(MAX_WIDTH);
  localparam int Y_BITS  = $clog2(MAX_HEIGHT);
  localparam int Z_BITS  = $clog2(MAX_DEPTH);
  localparam int WH_BITS = W_BITS + H_BITS;

  localparam int RING_LEN  = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3;
  localparam int RING_BITS = $clog2(RING_LEN);

  localparam int VOX_BITS  = 16;
  localparam int HIST_LEN  = 1 << VOX_BITS;
  localparam int HIST_BITS = VOX_BITS;
  localparam int WIN_SIZE  = 27;
  localparam int WIN_BITS  = $clog2(WIN_SIZE + 1);

  // (sum + 13) / 27 as (sum + 13) * ceil(2^26 / 27) >> 26, exact below 2^21
  localparam int SUM_BITS    = 21;
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_BITS  = 22;
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(((1 << RECIP_SHIFT) + 26) / 27);
  localparam logic [SUM_BITS-1:0] ROUND_BIAS = SUM_BITS'(13);
  localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_VOL_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VOL_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VOL_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_AUTO_BG    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_NOISE      = 3'd4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CORRECT = 1'b1;
  localparam logic KIND_BACKGROUND = 1'b0;
  localparam logic KIND_VOXEL      = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_SUM      = 10'b0000000010,
    ST_DRAIN    = 10'b0000000100,
    ST_MUL      = 10'b0000001000,
    ST_HIST_RD  = 10'b0000010000,
    ST_HIST_WR  = 10'b0000100000,
    ST_SCAN     = 10'b0001000000,
    ST_SCAN_END = 10'b0010000000,
    ST_EMIT     = 10'b0100000000,
    ST_CLEAR    = 10'b1000000000
  } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/bmbs_in_if.sv
// Input channel of the background estimator: valid/ready plus cmd and voxel.
// Depends on nothing.
`default_nettype none
interface bmbs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] voxel;
  modport source (output valid, output cmd, output voxel, input ready);
  modport sink (input valid, input cmd, input voxel, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bmbs_out_if.sv
// Result channel of the background estimator: valid/ready plus result fields.
// Depends on nothing.
`default_nettype none
interface bmbs_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] out_value;
  logic        no_interior;
  modport source (output valid, output result_kind, output out_value, output no_interior,
                  input ready);
  modport sink (input valid, input result_kind, input out_value, input no_interior,
                output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/box_mean_mode_background_subtract.sv
// Box-mean mode background estimator and subtractor, top level.
// Depends on bmbs_pkg, bmbs_in_if, bmbs_out_if and assert_macros.svh.
//
// Usage:
//  - in_chan beats carry cmd and voxel. cmd=0 loads a voxel of the volume in
//    raster order (x fastest, then y, then z); cmd=1 asks for a corrected voxel.
//  - out_chan beats carry result_kind, out_value and no_interior. A correct
//    beat always gives one result; a load beat gives a result only for the
//    last voxel of the volume (the mode of the 3x3x3 box means).
//  - cfg_we/cfg_index/cfg_wdata write the five registers; writing a
//    dimension restarts the volume and clears the histogram.
// Sequence:
//  - correct beat: result in the output register in the cycle after accept.
//  - load beat, border voxel: the state stays idle. Interior voxel: the
//    sequencer runs the 27 reads of the window from the plane memory, a drain
//    step, the divide multiply and the histogram read-modify-write.
//  - last voxel: then a scan of all 65536 histogram bins, clearing as it
//    reads; ST_SCAN_END, then ST_EMIT loads the output register.
// Reset: synchronous, rst_n low. Afterwards (and after any dimension write)
//  the histogram is cleared over all 65536 bins; in_chan.ready stays low.
// Stall: the output register holds its beat while out_chan.ready is low;
//  the next input beat is taken in the same cycle the held beat leaves.
`default_nettype none
`include "assert_macros.svh"
module box_mean_mode_background_subtract (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bmbs_in_if.sink                             in_chan,
  bmbs_out_if.source                          out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [bmbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [bmbs_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  // ---------------- configuration registers ----------------
  logic [bmbs_pkg::W_BITS-1:0]   vol_width_r;
  logic [bmbs_pkg::H_BITS-1:0]   vol_height_r;
  logic [bmbs_pkg::D_BITS-1:0]   vol_depth_r;
  logic                          auto_bg_r;
  logic [bmbs_pkg::VOX_BITS-1:0] noise_r;
  logic                          dim_write;

  assign dim_write = cfg_we && (cfg_index == bmbs_pkg::REG_VOL_WIDTH ||
                                cfg_index == bmbs_pkg::REG_VOL_HEIGHT ||
                                cfg_index == bmbs_pkg::REG_VOL_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_width_r  <= bmbs_pkg::W_BITS'(200);
      vol_height_r <= bmbs_pkg::H_BITS'(200);
      vol_depth_r  <= bmbs_pkg::D_BITS'(21);
      auto_bg_r    <= 1'b0;
      noise_r      <= bmbs_pkg::VOX_BITS'(270);
    end else if (cfg_we) begin
      case (cfg_index)
        bmbs_pkg::REG_VOL_WIDTH:  vol_width_r  <= cfg_wdata[bmbs_pkg::W_BITS-1:0];
        bmbs_pkg::REG_VOL_HEIGHT: vol_height_r <= cfg_wdata[bmbs_pkg::H_BITS-1:0];
        bmbs_pkg::REG_VOL_DEPTH:  vol_depth_r  <= cfg_wdata[bmbs_pkg::D_BITS-1:0];
        bmbs_pkg::REG_AUTO_BG:    auto_bg_r    <= cfg_wdata[0];
        bmbs_pkg::REG_NOISE:      noise_r      <= cfg_wdata[bmbs_pkg::VOX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // dimensions clamped to [3, MAX]
  logic [bmbs_pkg::W_BITS-1:0] w_use;
  logic [bmbs_pkg::H_BITS-1:0] h_use;
  logic [bmbs_pkg::D_BITS-1:0] d_use;
  always_comb begin
    w_use = vol_width_r;
    if (vol_width_r < bmbs_pkg::W_BITS'(3)) w_use = bmbs_pkg::W_BITS'(3);
    else if (vol_width_r > bmbs_pkg::W_BITS'(bmbs_pkg::MAX_WIDTH))
      w_use = bmbs_pkg::W_BITS'(bmbs_pkg::MAX_WIDTH);
    h_use = vol_height_r;
    if (vol_height_r < bmbs_pkg::H_BITS'(3)) h_use = bmbs_pkg::H_BITS'(3);
    else if (vol_height_r > bmbs_pkg::H_BITS'(bmbs_pkg::MAX_HEIGHT))
      h_use = bmbs_pkg::H_BITS'(bmbs_pkg::MAX_HEIGHT);
    d_use = vol_depth_r;
    if (vol_depth_r < bmbs_pkg::D_BITS'(3)) d_use = bmbs_pkg::D_BITS'(3);
    else if (vol_depth_r > bmbs_pkg::D_BITS'(bmbs_pkg::MAX_DEPTH))
      d_use = bmbs_pkg::D_BITS'(bmbs_pkg::MAX_DEPTH);
  end

  // slice size, registered; only used in ST_SUM, after an accept
  logic [bmbs_pkg::WH_BITS-1:0] wh_r;
  always_ff @(posedge clk) begin
    wh_r <= bmbs_pkg::WH_BITS'(w_use) * bmbs_pkg::WH_BITS'(h_use);
  end

  // ---------------- control state ----------------
  bmbs_pkg::state_t state_r, state_nxt;
  logic [bmbs_pkg::X_BITS-1:0]    pos_x_r;
  logic [bmbs_pkg::Y_BITS-1:0]    pos_y_r;
  logic [bmbs_pkg::Z_BITS-1:0]    pos_z_r;
  logic [bmbs_pkg::RING_BITS-1:0] ptr_r;
  logic [bmbs_pkg::RING_BITS-1:0] cur_ptr_r;
  logic                           last_r;
  logic [bmbs_pkg::WIN_BITS-1:0]  cnt_r;
  logic [1:0]                     dx_r, dy_r;
  logic [bmbs_pkg::RING_BITS-1:0] off_r;
  logic                           rv_r;
  logic [bmbs_pkg::SUM_BITS-1:0]  sum_r;
  logic [bmbs_pkg::PROD_BITS-1:0] prod_r;
  logic [bmbs_pkg::HIST_BITS-1:0] mean_r;
  logic [bmbs_pkg::HIST_BITS-1:0] scan_addr_r, cmp_addr_r;
  logic [bmbs_pkg::HIST_BITS-1:0] best_r;
  logic [bmbs_pkg::COUNT_BITS-1:0] best_cnt_r;
  logic [bmbs_pkg::VOX_BITS-1:0]  bg_r;

  logic out_valid_r, out_kind_r, out_noint_r;
  logic [bmbs_pkg::VOX_BITS-1:0] out_value_r;
  logic out_free;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == bmbs_pkg::ST_IDLE) && out_free;

  logic acc, acc_load, acc_corr;
  assign acc      = in_chan.valid && in_chan.ready;
  assign acc_load = acc && (in_chan.cmd == bmbs_pkg::CMD_LOAD);
  assign acc_corr = acc && (in_chan.cmd == bmbs_pkg::CMD_CORRECT);

  // position of the current load beat
  logic interior, x_end, y_end, z_end, vol_end;
  assign interior = pos_x_r >= bmbs_pkg::X_BITS'(2) && pos_y_r >= bmbs_pkg::Y_BITS'(2) &&
                    pos_z_r >= bmbs_pkg::Z_BITS'(2);
  assign x_end   = ({1'b0, pos_x_r} + 1'b1) >= w_use;
  assign y_end   = ({1'b0, pos_y_r} + 1'b1) >= h_use;
  assign z_end   = ({1'b0, pos_z_r} + 1'b1) >= d_use;
  assign vol_end = x_end && y_end && z_end;

  // ---------------- plane memory (delay line of the window) ----------------
  logic [bmbs_pkg::VOX_BITS-1:0] plane_mem [bmbs_pkg::RING_LEN];
  logic [bmbs_pkg::VOX_BITS-1:0] plane_q;
  logic [bmbs_pkg::RING_BITS-1:0] plane_raddr;
  logic [bmbs_pkg::RING_BITS:0]   wrap_sum;
  logic                           plane_re;

  assign wrap_sum = {1'b0, cur_ptr_r} + (bmbs_pkg::RING_BITS+1)'(bmbs_pkg::RING_LEN)
                    - {1'b0, off_r};
  assign plane_raddr = (cur_ptr_r >= off_r) ? (cur_ptr_r - off_r)
                                            : wrap_sum[bmbs_pkg::RING_BITS-1:0];
  assign plane_re = (state_r == bmbs_pkg::ST_SUM);

  always_ff @(posedge clk) begin
    if (acc_load) plane_mem[ptr_r] <= in_chan.voxel;
    if (plane_re) plane_q <= plane_mem[plane_raddr];
  end

  // offset steps inside the 3x3x3 window
  logic [bmbs_pkg::RING_BITS-1:0] row_step, slice_step;
  assign row_step   = bmbs_pkg::RING_BITS'(w_use) - bmbs_pkg::RING_BITS'(2);
  assign slice_step = bmbs_pkg::RING_BITS'(wh_r) - bmbs_pkg::RING_BITS'({w_use, 1'b0})
                      - bmbs_pkg::RING_BITS'(2);

  // ---------------- histogram memory ----------------
  logic [bmbs_pkg::COUNT_BITS-1:0] hist_mem [bmbs_pkg::HIST_LEN];
  logic [bmbs_pkg::COUNT_BITS-1:0] hist_q, hist_wdata;
  logic [bmbs_pkg::HIST_BITS-1:0]  hist_waddr, hist_raddr, mean_nxt;
  logic                            hist_we, hist_re;

  always_comb begin
    if (|prod_r[bmbs_pkg::PROD_BITS-1:bmbs_pkg::RECIP_SHIFT+bmbs_pkg::HIST_BITS])
      mean_nxt = '1;
    else
      mean_nxt = prod_r[bmbs_pkg::RECIP_SHIFT +: bmbs_pkg::HIST_BITS];
  end

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = scan_addr_r;
    hist_wdata = '0;
    hist_re    = 1'b0;
    hist_raddr = scan_addr_r;
    case (state_r)
      bmbs_pkg::ST_HIST_RD: begin
        hist_re    = 1'b1;
        hist_raddr = mean_nxt;
      end
      bmbs_pkg::ST_HIST_WR: begin
        hist_we    = 1'b1;
        hist_waddr = mean_r;
        hist_wdata = (hist_q == bmbs_pkg::COUNT_MAX) ? hist_q : hist_q + 1'b1;
      end
      bmbs_pkg::ST_SCAN: begin
        hist_re = 1'b1;
        hist_we = 1'b1;
      end
      bmbs_pkg::ST_CLEAR: begin
        hist_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (hist_re) hist_q <= hist_mem[hist_raddr];
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmbs_pkg::ST_IDLE:
        if (acc_load) begin
          if (interior)     state_nxt = bmbs_pkg::ST_SUM;
          else if (vol_end) state_nxt = bmbs_pkg::ST_SCAN;
        end
      bmbs_pkg::ST_SUM:
        if (cnt_r == bmbs_pkg::WIN_BITS'(bmbs_pkg::WIN_SIZE - 1)) state_nxt = bmbs_pkg::ST_DRAIN;
      bmbs_pkg::ST_DRAIN:   state_nxt = bmbs_pkg::ST_MUL;
      bmbs_pkg::ST_MUL:     state_nxt = bmbs_pkg::ST_HIST_RD;
      bmbs_pkg::ST_HIST_RD: state_nxt = bmbs_pkg::ST_HIST_WR;
      bmbs_pkg::ST_HIST_WR: state_nxt = last_r ? bmbs_pkg::ST_SCAN : bmbs_pkg::ST_IDLE;
      bmbs_pkg::ST_SCAN:
        if (&scan_addr_r) state_nxt = bmbs_pkg::ST_SCAN_END;
      bmbs_pkg::ST_SCAN_END: state_nxt = bmbs_pkg::ST_EMIT;
      bmbs_pkg::ST_EMIT:
        if (out_free) state_nxt = bmbs_pkg::ST_IDLE;
      bmbs_pkg::ST_CLEAR:
        if (&scan_addr_r) state_nxt = bmbs_pkg::ST_IDLE;
      default: state_nxt = bmbs_pkg::ST_IDLE;
    endcase
    if (dim_write) state_nxt = bmbs_pkg::ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmbs_pkg::ST_CLEAR;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      ptr_r       <= '0;
      scan_addr_r <= '0;
      rv_r        <= 1'b0;
      bg_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= plane_re || (state_r == bmbs_pkg::ST_SCAN);

      if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;

      if (acc_load) begin
        pos_x_r <= x_end ? '0 : pos_x_r + 1'b1;
        if (x_end) begin
          pos_y_r <= y_end ? '0 : pos_y_r + 1'b1;
          if (y_end) pos_z_r <= z_end ? '0 : pos_z_r + 1'b1;
        end
        if (vol_end) ptr_r <= '0;
        else ptr_r <= (ptr_r == bmbs_pkg::RING_BITS'(bmbs_pkg::RING_LEN - 1))
                      ? '0 : ptr_r + 1'b1;
      end

      if (acc_corr) out_valid_r <= 1'b1;

      if (state_r == bmbs_pkg::ST_SCAN || state_r == bmbs_pkg::ST_CLEAR)
        scan_addr_r <= scan_addr_r + 1'b1;

      if (state_r == bmbs_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        bg_r        <= (best_cnt_r == '0) ? '0 : best_r;
      end

      if (dim_write) begin
        pos_x_r     <= '0;
        pos_y_r     <= '0;
        pos_z_r     <= '0;
        ptr_r       <= '0;
        scan_addr_r <= '0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (acc_load) begin
      cur_ptr_r  <= ptr_r;
      last_r     <= vol_end;
      cnt_r      <= '0;
      dx_r       <= '0;
      dy_r       <= '0;
      off_r      <= '0;
      sum_r      <= '0;
      best_r     <= '0;
      best_cnt_r <= '0;
    end
    if (plane_re) begin
      cnt_r <= cnt_r + 1'b1;
      if (dx_r != 2'd2) begin
        dx_r  <= dx_r + 1'b1;
        off_r <= off_r + 1'b1;
      end else begin
        dx_r <= '0;
        if (dy_r != 2'd2) begin
          dy_r  <= dy_r + 1'b1;
          off_r <= off_r + row_step;
        end else begin
          dy_r  <= '0;
          off_r <= off_r + slice_step;
        end
      end
    end
    if (rv_r && (state_r == bmbs_pkg::ST_SUM || state_r == bmbs_pkg::ST_DRAIN))
      sum_r <= sum_r + bmbs_pkg::SUM_BITS'(plane_q);
    if (state_r == bmbs_pkg::ST_MUL)
      prod_r <= bmbs_pkg::PROD_BITS'(sum_r + bmbs_pkg::ROUND_BIAS) *
                bmbs_pkg::PROD_BITS'(bmbs_pkg::RECIP);
    if (state_r == bmbs_pkg::ST_HIST_RD) mean_r <= mean_nxt;
    cmp_addr_r <= scan_addr_r;
    // ascending scan with strict compare keeps the smallest mean on ties
    if (rv_r && (state_r == bmbs_pkg::ST_SCAN || state_r == bmbs_pkg::ST_SCAN_END) &&
        hist_q > best_cnt_r) begin
      best_cnt_r <= hist_q;
      best_r     <= cmp_addr_r;
    end
    if (acc_corr) begin
      out_kind_r  <= bmbs_pkg::KIND_VOXEL;
      out_noint_r <= 1'b0;
      if (auto_bg_r)
        out_value_r <= (in_chan.voxel > bg_r) ? in_chan.voxel - bg_r : '0;
      else
        out_value_r <= (in_chan.voxel > noise_r) ? in_chan.voxel - noise_r : '0;
    end
    if (state_r == bmbs_pkg::ST_EMIT && out_free) begin
      out_kind_r  <= bmbs_pkg::KIND_BACKGROUND;
      out_noint_r <= (best_cnt_r == '0);
      out_value_r <= (best_cnt_r == '0) ? '0 : best_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.out_value   = out_value_r;
  assign out_chan.no_interior = out_noint_r;

  // ---------------- checks ----------------
  `BMBS_ASSERT(a_sum_count, clk, rst_n, (state_r == bmbs_pkg::ST_SUM) |-> (cnt_r < bmbs_pkg::WIN_BITS'(bmbs_pkg::WIN_SIZE)))
  `BMBS_ASSERT(a_ring_addr, clk, rst_n, plane_re |-> (plane_raddr < bmbs_pkg::RING_BITS'(bmbs_pkg::RING_LEN)))
  `BMBS_ASSERT(a_hist_no_wrap, clk, rst_n, (state_r == bmbs_pkg::ST_HIST_WR) |-> (hist_wdata != '0))
  `BMBS_ASSERT(a_interior_sum, clk, rst_n, (acc_load && interior && !dim_write) |=> (state_r == bmbs_pkg::ST_SUM))
  `BMBS_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> (state_r == bmbs_pkg::ST_CLEAR && !out_valid_r))

endmodule
`default_nettype wire
